FILE: rtl/ecov_pkg.sv
package ecov_pkg;

    // input command codes
    localparam logic [1:0] CMD_TRACE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result kinds
    localparam logic RES_DATA  = 1'b0;
    localparam logic RES_CLEAR = 1'b1;

    // fixed field widths
    localparam int ADDR_W       = 64;
    localparam int READ_INDEX_W = 13;
    localparam int VALUE_W      = 64;

    // front/back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_INC,
        OP_READ,
        OP_CLEAR
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_RUN,
        BK_CLEAR
    } back_state_t;

endpackage

FILE: rtl/ecov_ram.sv
module ecov_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the write address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ecov_front.sv
module ecov_front #(
    parameter int ENTRIES = 8192,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [ecov_pkg::ADDR_W-1:0]         block_address,
    input  logic [ecov_pkg::READ_INDEX_W-1:0]   read_index,
    input  logic                                init_busy,
    input  logic                                q_full,
    output logic                                q_push,
    output ecov_pkg::op_kind_t                  q_kind,
    output logic [IDX_W-1:0]                    q_idx
);

    import ecov_pkg::*;

    logic             collect_enable_reg;
    logic             collect_enable_next;
    logic [IDX_W-1:0] prev_loc_reg;
    logic [IDX_W-1:0] prev_loc_next;
    logic             accept;
    logic [IDX_W-1:0] cur;
    logic [IDX_W+READ_INDEX_W-1:0] read_index_ext;

    assign in_ready = !q_full && !init_busy;
    assign accept   = in_valid && in_ready;
    assign cur      = block_address[IDX_W-1:0];

    // read index wraps to the table size
    assign read_index_ext = {{IDX_W{1'b0}}, read_index};

    always_comb
    begin
        collect_enable_next = cfg_wr_en ? cfg_wr_data : collect_enable_reg;
        prev_loc_next       = prev_loc_reg;
        q_push              = 1'b0;
        q_kind              = OP_INC;
        q_idx               = cur ^ prev_loc_reg;
        unique case (cmd)
            CMD_TRACE:
            begin
                if (accept && collect_enable_reg)
                begin
                    q_push        = 1'b1;
                    prev_loc_next = cur >> 1;
                end
            end
            CMD_READ:
            begin
                q_push = accept;
                q_kind = OP_READ;
                q_idx  = read_index_ext[IDX_W-1:0];
            end
            CMD_CLEAR:
            begin
                q_push = accept;
                q_kind = OP_CLEAR;
            end
            default:
            begin
                // unused command: taken and dropped
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collect_enable_reg <= 1'b0;
            prev_loc_reg       <= '0;
        end
        else
        begin
            collect_enable_reg <= collect_enable_next;
            prev_loc_reg       <= prev_loc_next;
        end
    end

endmodule

FILE: rtl/ecov_queue.sv
module ecov_queue #(
    parameter int ENTRIES = 8192,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ecov_pkg::op_kind_t push_kind,
    input  logic [IDX_W-1:0]   push_idx,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output ecov_pkg::op_kind_t head_kind,
    output logic [IDX_W-1:0]   head_idx
);

    import ecov_pkg::*;

    op_kind_t          kind_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]  idx_reg  [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_kind  = kind_reg[rd_ptr_reg];
    assign head_idx   = idx_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wr_ptr_reg] <= push_kind;
            idx_reg[wr_ptr_reg]  <= push_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/ecov_back.sv
module ecov_back #(
    parameter int ENTRIES = 8192,
    parameter int COUNT_WIDTH = 64,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  ecov_pkg::op_kind_t             q_kind,
    input  logic [IDX_W-1:0]               q_idx,
    output logic                           q_pop,
    output logic                           init_busy,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           result_kind,
    output logic [ecov_pkg::VALUE_W-1:0]   counter_value
);

    import ecov_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [IDX_W-1:0]       sweep_cnt_reg;
    logic [IDX_W-1:0]       sweep_cnt_next;
    logic                   sweep_last;
    logic                   sweeping;

    // read-modify-write stage (RAM read data lands here)
    logic                   b_valid_reg;
    logic                   b_valid_next;
    op_kind_t               b_kind_reg;
    logic [IDX_W-1:0]       b_idx_reg;

    // last write, for forwarding past the read-first RAM
    logic                   fwd_valid_reg;
    logic [IDX_W-1:0]       fwd_idx_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_kind_reg;
    logic                   out_kind_next;
    logic [VALUE_W-1:0]     out_value_reg;
    logic [VALUE_W-1:0]     out_value_next;

    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] cur_data;
    logic                   b_result;
    logic                   b_inc;

    ecov_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(q_idx),
        .rdata(rdata)
    );

    assign sweep_last = &sweep_cnt_reg;
    assign b_result   = b_valid_reg && (b_kind_reg == OP_READ);
    assign b_inc      = b_valid_reg && (b_kind_reg == OP_INC);
    assign cur_data   = (fwd_valid_reg && (fwd_idx_reg == b_idx_reg)) ? fwd_data_reg : rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (q_pop && (q_kind == OP_CLEAR))
                begin
                    state_next = BK_CLEAR;
                end
            end
            BK_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_INIT;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        init_busy = 1'b0;
        sweeping  = 1'b0;
        q_pop     = 1'b0;
        unique case (state_reg)
            BK_INIT:
            begin
                init_busy = 1'b1;
                sweeping  = 1'b1;
            end
            BK_RUN:
            begin
                // a result op waits until the output register is sure to be free
                q_pop = q_valid && ((q_kind == OP_INC) || (!out_valid_reg && !b_result));
            end
            BK_CLEAR:
            begin
                sweeping = 1'b1;
            end
            default:
            begin
                init_busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        sweep_cnt_next = sweeping ? sweep_cnt_reg + 1'b1 : sweep_cnt_reg;
        b_valid_next   = q_pop && (q_kind != OP_CLEAR);

        we    = 1'b0;
        waddr = b_idx_reg;
        wdata = cur_data + 1'b1;
        if (sweeping)
        begin
            we    = 1'b1;
            waddr = sweep_cnt_reg;
            wdata = '0;
        end
        else if (b_inc)
        begin
            we = 1'b1;
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        if (b_result)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = RES_DATA;
            out_value_next = VALUE_W'(cur_data);
        end
        else if ((state_reg == BK_CLEAR) && sweep_last)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = RES_CLEAR;
            out_value_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_kind_reg <= q_kind;
            b_idx_reg  <= q_idx;
        end
        fwd_idx_reg   <= waddr;
        fwd_data_reg  <= wdata;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            sweep_cnt_reg <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            b_valid_reg   <= b_valid_next;
            fwd_valid_reg <= we;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_kind_reg;
    assign counter_value = out_value_reg;

endmodule

FILE: rtl/edge_coverage_counter_core.sv
// Edge coverage counter table. Trace beats (cmd 0, only while collect_enable
// is set) bump the counter at (address ^ previous location): the front end
// classifies a beat per cycle into a four-entry queue while it is not full,
// and the back end does one RAM read-modify-write per cycle outside a clear
// sweep, with the last write forwarded. Read beats return one result each
// and wait in the queue until the single output register is sure to be
// free. A clear beat sweeps the RAM write port one word per cycle over all
// ENTRIES words, then returns an acknowledge. After reset the same clearing
// pass runs with in_ready held low; configuration writes are still taken.
module edge_coverage_counter_core #(
    parameter int ENTRIES = 8192,
    parameter int COUNT_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [ecov_pkg::ADDR_W-1:0]         block_address,
    input  logic [ecov_pkg::READ_INDEX_W-1:0]   read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                result_kind,
    output logic [ecov_pkg::VALUE_W-1:0]        counter_value
);

    import ecov_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic             init_busy;
    logic             push;
    op_kind_t         push_kind;
    logic [IDX_W-1:0] push_idx;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    op_kind_t         q_kind;
    logic [IDX_W-1:0] q_idx;

    ecov_front #(
        .ENTRIES(ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .block_address(block_address),
        .read_index   (read_index),
        .init_busy    (init_busy),
        .q_full       (q_full),
        .q_push       (push),
        .q_kind       (push_kind),
        .q_idx        (push_idx)
    );

    ecov_queue #(
        .ENTRIES(ENTRIES)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_kind (push_kind),
        .push_idx  (push_idx),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_kind (q_kind),
        .head_idx  (q_idx)
    );

    ecov_back #(
        .ENTRIES    (ENTRIES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_kind       (q_kind),
        .q_idx        (q_idx),
        .q_pop        (q_pop),
        .init_busy    (init_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .counter_value(counter_value)
    );

endmodule

FILE: rtl/ecov_checker.sv
module ecov_checker #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         result_kind,
    input  logic [ecov_pkg::VALUE_W-1:0] counter_value
);

    import ecov_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(counter_value))
        else $error("result beat changed while stalled");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RES_CLEAR) |-> counter_value == '0)
        else $error("clear acknowledge carries nonzero value");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RES_DATA) |-> (counter_value >> COUNT_WIDTH) == '0)
        else $error("counter value wider than counter");

    // clearing pass after reset blocks input
    a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input accepted during reset clearing pass");

endmodule

bind edge_coverage_counter_core ecov_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_ecov_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .counter_value(counter_value)
);
